### sv/swv_pkg.sv
// ----------------------------------------------------------------------------
// swv_pkg: shared widths and constants for the sliding window VWAP unit.
// Holds the fixed field widths and the reset value of the window register.
// ----------------------------------------------------------------------------
package swv_pkg;

  // Field widths of the input and result beats.
  localparam int PRICE_W  = 28;
  localparam int VOL_W    = 24;
  localparam int VWAP_W   = 44;
  localparam int CFG_W    = 11;

  // Running sum widths, exact for the largest window.
  localparam int VALUE_W  = 63;
  localparam int VOLTOT_W = 34;
  localparam int DEN_W    = VOLTOT_W + 1;

  // Fraction bits of the VWAP result.
  localparam int FRAC_W   = 16;

  // Window length after reset.
  localparam int WINDOW_RESET = 1000;

endpackage

### sv/swv_in_if.sv
// ----------------------------------------------------------------------------
// swv_in_if: quote tick channel.
// Valid/ready channel that carries one quote tick per beat.
// ----------------------------------------------------------------------------
interface swv_in_if
  import swv_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] bid_px;
  logic [PRICE_W-1:0] ask_px;
  logic [VOL_W-1:0]   bid_qty;
  logic [VOL_W-1:0]   ask_qty;

  modport source (output valid, bid_px, ask_px, bid_qty, ask_qty,
                  input ready);
  modport sink   (input valid, bid_px, ask_px, bid_qty, ask_qty,
                  output ready);
endinterface

### sv/swv_out_if.sv
// ----------------------------------------------------------------------------
// swv_out_if: VWAP result channel.
// Valid/ready channel that carries one VWAP result per beat.
// ----------------------------------------------------------------------------
interface swv_out_if
  import swv_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [VWAP_W-1:0] vwap_price;
  logic              window_full;

  modport source (output valid, vwap_price, window_full, input ready);
  modport sink   (input valid, vwap_price, window_full, output ready);
endinterface

### sv/swv_div.sv
// ----------------------------------------------------------------------------
// swv_div: radix-2 restoring divider for the VWAP quotient.
// Computes floor(num * 2^FRAC_W / den), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swv_div
  import swv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [VALUE_W-1:0]  num,
  input  logic [DEN_W-1:0]    den,
  output logic                done,
  output logic [VWAP_W-1:0]   quo
);

  localparam int LOW_W = VALUE_W - DEN_W;
  localparam int CNT_W = $clog2(VWAP_W + 1);

  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [VWAP_W-1:0] num_r, quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [DEN_W:0]    rem_sh;
  logic              take;

  // One trial subtraction of the shifted remainder.
  always_comb begin
    rem_sh  = {rem_r, num_r[VWAP_W-1]};
    take    = (rem_sh >= {1'b0, den_r});
    rem_nxt = take ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
  end

  // Iteration control; the top bits of the numerator seed the remainder,
  // which stays below den because the quotient fits VWAP_W bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(VWAP_W);
        rem_r  <= num[VALUE_W-1:LOW_W];
        num_r  <= {num[LOW_W-1:0], {FRAC_W{1'b0}}};
        den_r  <= den;
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        num_r <= {num_r[VWAP_W-2:0], 1'b0};
        quo_r <= {quo_r[VWAP_W-2:0], take};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### sv/sliding_window_vwap_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_vwap_unit: volume weighted average mid price over a window.
// Ring memories hold each tick's doubled mid price and volume; running sums
// are updated per tick and a serial divider forms the VWAP.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   bid_px, ask_px, bid_qty, ask_qty
//  out_ch   out  valid/ready   vwap_price, window_full
//  cfg      in   cfg_we        cfg_wdata (window length)
//
// A tick that arrives when the window is full and the volume nonzero passes
// through ST_MUL, ST_ACC, ST_CHK, the serial divider (ST_DIV) and ST_OUT;
// otherwise ST_DIV is skipped. Reset and a window write clear the pointer,
// tick count and sums; the ring is never cleared. A result waits in the
// output register while the next tick is already accepted.
// ----------------------------------------------------------------------------
module sliding_window_vwap_unit
  import swv_pkg::*;
#(
  parameter int MAX_WINDOW  = 1024,
  parameter int PRICE_BITS  = 28,
  parameter int VOLUME_BITS = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  swv_in_if.sink           in_ch,
  swv_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int MW   = PRICE_BITS + 1;
  localparam int PW   = MW + VOLUME_BITS;
  localparam int WRST = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_CHK, ST_DIV, ST_OUT
  } state_t;

  state_t              state_r;
  logic [CW-1:0]       win_r;
  logic [AW-1:0]       wp_r;
  logic [CW-1:0]       ticks_r;
  logic [VALUE_W-1:0]  value_r;
  logic [VOLTOT_W-1:0] voltot_r;
  logic                sub_r, full_r;
  logic [MW-1:0]       mid_r;
  logic [VOLUME_BITS-1:0] vol_r;
  logic [PW-1:0]       pnew_r, pold_r;
  logic [VWAP_W-1:0]   res_r;
  logic                out_valid_r;
  logic [VWAP_W-1:0]   out_vwap_r;
  logic                out_full_r;

  // Ring storage.
  logic [MW-1:0]          mem_mid [MAX_WINDOW];
  logic [VOLUME_BITS-1:0] mem_vol [MAX_WINDOW];
  logic [MW-1:0]          rd_mid_r;
  logic [VOLUME_BITS-1:0] rd_vol_r;

  logic                   accept;
  logic [MW-1:0]          mid_in;
  logic [VOLUME_BITS:0]   vsum_in;
  logic [AW:0]            old_sum;
  logic [AW-1:0]          old_addr;
  logic [CW-1:0]          ticks_nxt;
  logic [CW-1:0]          cfg_win;
  logic                   div_start, div_done;
  logic [VWAP_W-1:0]      div_quo;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // Reduce the tick to a doubled mid price and a halved volume.
  always_comb begin
    mid_in  = {1'b0, in_ch.bid_px[PRICE_BITS-1:0]}
            + {1'b0, in_ch.ask_px[PRICE_BITS-1:0]};
    vsum_in = {1'b0, in_ch.bid_qty[VOLUME_BITS-1:0]}
            + {1'b0, in_ch.ask_qty[VOLUME_BITS-1:0]};
  end

  // Slot of the entry that leaves the window.
  always_comb begin
    old_sum = {1'b0, wp_r} + (AW+1)'(MAX_WINDOW) - (AW+1)'(win_r);
    if (old_sum >= (AW+1)'(MAX_WINDOW)) begin
      old_addr = AW'(old_sum - (AW+1)'(MAX_WINDOW));
    end else begin
      old_addr = old_sum[AW-1:0];
    end
    ticks_nxt = (ticks_r >= win_r) ? ticks_r : ticks_r + 1'b1;
  end

  // Window length saturates at both ends.
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_win = CW'(1);
    end else if (cfg_wdata > CFG_W'(MAX_WINDOW)) begin
      cfg_win = CW'(MAX_WINDOW);
    end else begin
      cfg_win = cfg_wdata[CW-1:0];
    end
  end

  // Ring memories: read-first, so a full-size window sees the old entry.
  always_ff @(posedge clk) begin
    rd_mid_r <= mem_mid[old_addr];
    rd_vol_r <= mem_vol[old_addr];
    if (accept) begin
      mem_mid[wp_r] <= mid_in;
      mem_vol[wp_r] <= vsum_in[VOLUME_BITS:1];
    end
  end

  assign div_start = (state_r == ST_CHK) && full_r && (voltot_r != '0);

  swv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (value_r),
    .den   ({voltot_r, 1'b0}),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Sequencer, running sums and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= CW'(WRST);
      wp_r        <= '0;
      ticks_r     <= '0;
      value_r     <= '0;
      voltot_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a finished result, or drop a beat that has been taken.
      if (state_r == ST_OUT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
        out_vwap_r  <= res_r;
        out_full_r  <= full_r;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        win_r    <= cfg_win;
        wp_r     <= '0;
        ticks_r  <= '0;
        value_r  <= '0;
        voltot_r <= '0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            mid_r   <= mid_in;
            vol_r   <= vsum_in[VOLUME_BITS:1];
            sub_r   <= (ticks_r >= win_r);
            full_r  <= (ticks_nxt >= win_r);
            ticks_r <= ticks_nxt;
            wp_r    <= (wp_r == AW'(MAX_WINDOW - 1)) ? '0 : wp_r + 1'b1;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          pnew_r  <= mid_r * vol_r;
          pold_r  <= sub_r ? rd_mid_r * rd_vol_r : '0;
          if (sub_r) begin
            voltot_r <= voltot_r - VOLTOT_W'(rd_vol_r) + VOLTOT_W'(vol_r);
          end else begin
            voltot_r <= voltot_r + VOLTOT_W'(vol_r);
          end
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          value_r <= value_r + VALUE_W'(pnew_r) - VALUE_W'(pold_r);
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          res_r   <= '0;
          state_r <= div_start ? ST_DIV : ST_OUT;
        end
        ST_DIV: begin
          if (div_done) begin
            res_r   <= div_quo;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.vwap_price  = out_vwap_r;
  assign out_ch.window_full = out_full_r;

  // Checks on the sequencer and the window bookkeeping.
  a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ticks_r <= win_r) else $error("tick count above window length");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r < AW'(MAX_WINDOW - 1) || wp_r == AW'(MAX_WINDOW - 1))
    else $error("write pointer out of ring");

  a_zero_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_full_r |-> out_vwap_r == '0)
    else $error("nonzero VWAP with a partial window");

  a_div_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> full_r && voltot_r != '0)
    else $error("divider started without a full window");

endmodule

### tb/swv_tb_if.sv
// ----------------------------------------------------------------------------
// swv_tb_if: testbench view of the VWAP unit channels.
// The channel interfaces themselves come with the RTL; this file only
// collects the beat types that the driver and monitor queues carry.
// ----------------------------------------------------------------------------
package swv_tb_pkg;
  import swv_pkg::*;

  // One quote tick as driven on the input channel.
  typedef struct packed {
    logic [PRICE_W-1:0] bid_px;
    logic [PRICE_W-1:0] ask_px;
    logic [VOL_W-1:0]   bid_qty;
    logic [VOL_W-1:0]   ask_qty;
  } tick_t;

  // One VWAP result as seen on the output channel.
  typedef struct packed {
    logic [VWAP_W-1:0] vwap_price;
    logic              window_full;
  } vwap_t;
endpackage

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for sliding_window_vwap_unit.
// Ticks are driven from a queue with random idle cycles; a predictor keeps
// its own ring and running sums and checks every VWAP beat in order. The
// window length is changed between phases while the unit is drained.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import swv_pkg::*;
  import swv_tb_pkg::*;

  localparam int RING_DEPTH = 1024;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  swv_in_if  in_ch ();
  swv_out_if out_ch ();

  sliding_window_vwap_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state.
  logic [28:0]         mid_ring [RING_DEPTH];
  logic [VOL_W-1:0]    vol_ring [RING_DEPTH];
  logic [9:0]          slot_ptr;
  int unsigned         tick_count;
  int unsigned         win_len;
  logic [VALUE_W-1:0]  value_sum;
  logic [VOLTOT_W-1:0] volume_sum;

  tick_t tick_queue[$];
  vwap_t vwap_expected[$];
  int    fail_count = 0;
  bit    quiet_idle = 1'b0;

  function automatic void clear_window(int unsigned raw_len);
    win_len = (raw_len == 0) ? 1 : ((raw_len > RING_DEPTH) ? RING_DEPTH : raw_len);
    slot_ptr = '0;
    tick_count = 0;
    value_sum = '0;
    volume_sum = '0;
  endfunction

  // Computes the VWAP beat that one accepted tick produces.
  function automatic vwap_t vwap_for_tick(tick_t t);
    logic [28:0]          mid2;
    logic [VOL_W-1:0]     vol;
    logic [9:0]           old_slot;
    logic [24:0]          vol_sum2;
    logic [VOLTOT_W:0]    den;
    logic [VALUE_W+FRAC_W-1:0] num;
    vwap_t r;
    mid2 = {1'b0, t.bid_px} + {1'b0, t.ask_px};
    vol_sum2 = {1'b0, t.bid_qty} + {1'b0, t.ask_qty};
    vol = vol_sum2[24:1];
    if (tick_count >= win_len) begin
      old_slot = slot_ptr - 10'(win_len);
      value_sum = value_sum - VALUE_W'(mid_ring[old_slot]) * VALUE_W'(vol_ring[old_slot]);
      volume_sum = volume_sum - VOLTOT_W'(vol_ring[old_slot]);
    end else begin
      tick_count++;
    end
    mid_ring[slot_ptr] = mid2;
    vol_ring[slot_ptr] = vol;
    value_sum = value_sum + VALUE_W'(mid2) * VALUE_W'(vol);
    volume_sum = volume_sum + VOLTOT_W'(vol);
    slot_ptr = slot_ptr + 10'd1;
    r.window_full = (tick_count >= win_len);
    r.vwap_price = '0;
    if (r.window_full && volume_sum != 0) begin
      den = {volume_sum, 1'b0};
      num = {value_sum, {FRAC_W{1'b0}}};
      r.vwap_price = VWAP_W'(num / den);
    end
    return r;
  endfunction

  function automatic tick_t rand_tick(bit heavy);
    tick_t t;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    t.bid_px  = $urandom();
    t.ask_px  = $urandom();
    t.bid_qty = $urandom();
    t.ask_qty = $urandom();
    if (!heavy && kind < 6) begin
      // Realistic quotes: ask near bid, modest volumes.
      t.bid_px  = $urandom_range(1000000, 200000000);
      t.ask_px  = t.bid_px + $urandom_range(0, 500);
      t.bid_qty = $urandom_range(0, 5000);
      t.ask_qty = $urandom_range(0, 5000);
    end else if (kind == 6) begin
      // Zero volume ticks exercise the empty volume case.
      t.bid_qty = '0;
      t.ask_qty = $urandom_range(0, 1);
    end
    return t;
  endfunction

  // Input driver: one beat per handshake, random idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.bid_px  <= '0;
      in_ch.ask_px  <= '0;
      in_ch.bid_qty <= '0;
      in_ch.ask_qty <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (tick_queue.size() > 0 && (quiet_idle || $urandom_range(0, 99) >= 31)) begin
        in_ch.valid   <= 1'b1;
        in_ch.bid_px  <= tick_queue[0].bid_px;
        in_ch.ask_px  <= tick_queue[0].ask_px;
        in_ch.bid_qty <= tick_queue[0].bid_qty;
        in_ch.ask_qty <= tick_queue[0].ask_qty;
        vwap_expected.insert(vwap_expected.size(), vwap_for_tick(tick_queue[0]));
        tick_queue.delete(0);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, compare each beat with the oldest expectation.
  always @(posedge clk) begin
    vwap_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (vwap_expected.size() == 0) begin
          $error("unexpected result beat");
          fail_count++;
        end else begin
          want = vwap_expected[0];
          vwap_expected.delete(0);
          if (out_ch.vwap_price !== want.vwap_price) begin
            $error("vwap_price expected %0d actual %0d", want.vwap_price, out_ch.vwap_price);
            fail_count++;
          end
          if (out_ch.window_full !== want.window_full) begin
            $error("window_full expected %0d actual %0d", want.window_full,
                   out_ch.window_full);
            fail_count++;
          end
        end
      end
      out_ch.ready <= quiet_idle || ($urandom_range(0, 99) >= 31);
    end
  end

  task automatic wait_drained();
    while (tick_queue.size() > 0 || in_ch.valid || vwap_expected.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(int unsigned len);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
    clear_window(len);
  endtask

  task automatic queue_tick(tick_t t);
    tick_queue.insert(tick_queue.size(), t);
  endtask

  task automatic push_ticks(int unsigned n, bit heavy);
    repeat (n) queue_tick(rand_tick(heavy));
  endtask

  initial begin
    tick_t t;
    clear_window(WINDOW_RESET);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes with a window of 3, then zero volume with window 1.
    write_window(3);
    t = '0;
    queue_tick(t);
    t = '1;
    queue_tick(t);
    t.bid_px = '1; t.ask_px = '0; t.bid_qty = '1; t.ask_qty = '0;
    queue_tick(t);
    t.bid_px = '0; t.ask_px = '1; t.bid_qty = 1; t.ask_qty = 0;
    queue_tick(t);
    t = '1;
    repeat (3) queue_tick(t);
    t.bid_px = 28'h5555555; t.ask_px = 28'hAAAAAAA;
    t.bid_qty = 24'hAAAAAA; t.ask_qty = 24'h555555;
    queue_tick(t);
    write_window(0);
    t = '0; t.bid_px = 28'd100;
    queue_tick(t);
    t.bid_qty = 24'd3;
    queue_tick(t);
    write_window(1);
    push_ticks(4, 1'b1);
    // Pause the sender until every expected beat is back.
    wait_drained();

    // Random phases with several window lengths, extremes included.
    write_window(2047);
    push_ticks(60, 1'b1);
    write_window(250);
    quiet_idle = 1'b1;
    push_ticks(300, 1'b0);
    wait_drained();
    quiet_idle = 1'b0;
    write_window(1024);
    push_ticks(5, 1'b0);
    write_window(1023);
    push_ticks(5, 1'b0);
    write_window(5);
    push_ticks(200, 1'b1);
    write_window($urandom_range(2, 40));
    push_ticks(150, 1'b0);
    write_window(1);
    push_ticks(50, 1'b0);
    write_window(17);
    push_ticks(66, 1'b0);

    wait_drained();
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #(8ns * 400000);
    $display("== FAIL ==");
    $finish;
  end
endmodule
